FILE: rtl/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants for the masked 3x3 lightmap smoother.
// ----------------------------------------------------------------------------
package msm_pkg;

    localparam int NCOMP  = 9;   // energy components per patch
    localparam int DW     = 32;  // Q15.16 component width
    localparam int IDXW   = 12;  // patch index width
    localparam int SIZEW  = 9;   // grid size register width
    localparam int NW     = 17;  // neighbour index width (255*256+255 fits)
    localparam int SUMW   = 38;  // weighted sum, 36 * 2^31 magnitude
    localparam int WTW    = 6;   // total weight 16..36
    localparam int STEPW  = 4;   // neighbour step counter, 0..8
    localparam int DIGITS = 4;   // quotient bits per divider cycle

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WRAP_H = 2'd2;
    localparam logic [1:0] CFG_WRAP_V = 2'd3;

    // weight as left shift: centre 16, edge 4, corner 1
    localparam logic [2:0] SH_CENTRE = 3'd4;
    localparam logic [2:0] SH_EDGE   = 3'd2;
    localparam logic [2:0] SH_CORNER = 3'd0;

    typedef struct packed {
        logic                 opcode;
        logic [IDXW-1:0]      patch_index;
        logic                 inside_flag;
        logic signed [DW-1:0] unradiated_x;
        logic signed [DW-1:0] unradiated_y;
        logic signed [DW-1:0] unradiated_z;
        logic signed [DW-1:0] total_x;
        logic signed [DW-1:0] total_y;
        logic signed [DW-1:0] total_z;
        logic signed [DW-1:0] from_dir_x;
        logic signed [DW-1:0] from_dir_y;
        logic signed [DW-1:0] from_dir_z;
    } t_in_item;

    typedef struct packed {
        logic [IDXW-1:0]      result_index;
        logic signed [DW-1:0] smooth_unrad_x;
        logic signed [DW-1:0] smooth_unrad_y;
        logic signed [DW-1:0] smooth_unrad_z;
        logic signed [DW-1:0] smooth_total_x;
        logic signed [DW-1:0] smooth_total_y;
        logic signed [DW-1:0] smooth_total_z;
        logic signed [DW-1:0] smooth_dir_x;
        logic signed [DW-1:0] smooth_dir_y;
        logic signed [DW-1:0] smooth_dir_z;
    } t_out_item;

    typedef struct packed {
        logic       acc_en;
        logic       first;
        logic [2:0] shift;
        logic       div_start;
        logic       div_step;
    } t_lane_ctl;

    // step 0 is the centre, steps 1..8 walk the ring row by row
    function automatic logic signed [1:0] nb_dx(input logic [STEPW-1:0] s);
        logic signed [1:0] d;
        unique case (s)
            4'd1, 4'd4, 4'd6: d = -2'sd1;
            4'd3, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [STEPW-1:0] s);
        logic signed [1:0] d;
        unique case (s)
            4'd1, 4'd2, 4'd3: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] nb_shift(input logic [STEPW-1:0] s);
        logic [2:0] r;
        unique case (s)
            4'd0:                     r = SH_CENTRE;
            4'd2, 4'd4, 4'd5, 4'd7:   r = SH_EDGE;
            default:                  r = SH_CORNER;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/msm_lane.sv
// ----------------------------------------------------------------------------
// msm_lane
// One energy component: patch store, weighted accumulator and a
// rounding divider producing four quotient bits per cycle.
// ----------------------------------------------------------------------------
module msm_lane #(
    parameter int MAX_PATCHES = 4096,
    localparam int AW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [msm_pkg::DW-1:0]    i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    input  msm_pkg::t_lane_ctl        i_ctl,
    input  logic [msm_pkg::WTW-1:0]   i_weight,
    output logic [msm_pkg::DW-1:0]    o_smooth,
    output logic [msm_pkg::DW-1:0]    o_centre
);

    logic [msm_pkg::DW-1:0]          r_mem [MAX_PATCHES];
    logic [msm_pkg::DW-1:0]          r_rdata;
    logic signed [msm_pkg::SUMW-1:0] r_sum;
    logic [msm_pkg::DW-1:0]          r_centre;
    logic                            r_neg;
    logic [msm_pkg::WTW-1:0]         r_rem;
    logic [msm_pkg::DW-1:0]          r_q;

    logic signed [msm_pkg::SUMW-1:0] w_ext;
    logic signed [msm_pkg::SUMW-1:0] n_sum;
    logic [msm_pkg::SUMW-1:0]        w_mag;
    logic [msm_pkg::SUMW-1:0]        w_madd;
    logic [msm_pkg::WTW-1:0]         n_rem;
    logic [msm_pkg::DW-1:0]          n_q;
    logic [msm_pkg::WTW:0]           w_t;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    always_comb begin
        w_ext  = msm_pkg::SUMW'($signed(r_rdata));
        n_sum  = (i_ctl.first ? '0 : r_sum) + (w_ext <<< i_ctl.shift);
        w_mag  = r_sum[msm_pkg::SUMW-1] ? msm_pkg::SUMW'(-r_sum) : msm_pkg::SUMW'(r_sum);
        // half the weight added for round-half-away on the magnitude
        w_madd = w_mag + msm_pkg::SUMW'(i_weight[msm_pkg::WTW-1:1]);
        n_rem  = r_rem;
        n_q    = r_q;
        for (int i = 0; i < msm_pkg::DIGITS; i++) begin
            w_t = {n_rem, n_q[msm_pkg::DW-1]};
            n_q = {n_q[msm_pkg::DW-2:0], 1'b0};
            if (w_t >= {1'b0, i_weight}) begin
                n_rem  = msm_pkg::WTW'(w_t - {1'b0, i_weight});
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_t[msm_pkg::WTW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_sum <= n_sum;
            if (i_ctl.first) begin
                r_centre <= r_rdata;
            end
        end
        // quotient fits 32 bits: an average of 32-bit values
        if (i_ctl.div_start) begin
            r_neg <= r_sum[msm_pkg::SUMW-1];
            r_rem <= w_madd[msm_pkg::SUMW-1:msm_pkg::DW];
            r_q   <= w_madd[msm_pkg::DW-1:0];
        end else if (i_ctl.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_smooth = r_q[msm_pkg::DW-1]
                    ? (r_neg ? {1'b1, {(msm_pkg::DW-1){1'b0}}} : {1'b0, {(msm_pkg::DW-1){1'b1}}})
                    : (r_neg ? (~r_q + 1'b1) : r_q);
    assign o_centre = r_centre;

endmodule

FILE: rtl/msm_mask.sv
// ----------------------------------------------------------------------------
// msm_mask
// Inside-bit store with a clearing pass after reset.
// ----------------------------------------------------------------------------
module msm_mask #(
    parameter int MAX_PATCHES = 4096,
    localparam int AW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_bit,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_bit,
    output logic          o_busy
);

    logic          r_mem [MAX_PATCHES];
    logic          r_rd;
    logic          r_busy;
    logic [AW-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            if (r_clr == AW'(MAX_PATCHES - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_bit;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_bit = r_rd;
    assign o_busy   = r_busy;

endmodule

FILE: rtl/masked_3x3_lightmap_smoother.sv
// ----------------------------------------------------------------------------
// masked_3x3_lightmap_smoother
// Patch grid store with a masked, normalised 3x3 weighted smoothing query.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | word
//  in       | input     | i_in_valid / o_in_stall   | t_in_item
//  out      | output    | o_out_valid / i_out_stall | t_out_item
//  cfg      | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
//  A store does not hold the input. A query holds it through acceptance, row/column
//  division (4-bit radix divider), 9 neighbour reads through each lane's single read
//  port plus a drain, the start and steps of the nine-lane rounding divider and the
//  load of the result word, which waits while the output stalls.
//  After reset the inside-mask clearing pass clears every entry with the input
//  stalled. A waiting result does not block stores.
// ----------------------------------------------------------------------------
module masked_3x3_lightmap_smoother #(
    parameter int MAX_PATCHES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  msm_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output msm_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [msm_pkg::SIZEW-1:0]    i_cfg_wdata
);

    localparam int AW = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
    localparam int RC_STEPS = msm_pkg::IDXW / msm_pkg::DIGITS;
    localparam int Q_STEPS  = msm_pkg::DW / msm_pkg::DIGITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RC    = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_QST   = 3'd4;
    localparam logic [2:0] ST_QDIV  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [msm_pkg::SIZEW-1:0] r_width, r_height;
    logic                      r_wrap_h, r_wrap_v;
    logic [2:0]                r_state;
    logic [msm_pkg::IDXW-1:0]  r_idx;
    logic                      r_idx_ok;
    logic [msm_pkg::IDXW-1:0]  r_dq;     // dividend, then row
    logic [msm_pkg::SIZEW-1:0] r_drem;   // remainder, then column
    logic [1:0]                r_dstep;
    logic [msm_pkg::STEPW-1:0] r_step;
    logic                      r_pact, r_pfirst, r_pv;
    logic [2:0]                r_pshift;
    logic [msm_pkg::WTW-1:0]   r_wsum;
    logic                      r_cmask;
    logic [2:0]                r_qstep;
    logic                      r_ovalid;
    msm_pkg::t_out_item        r_odata;

    logic [msm_pkg::SIZEW-1:0] w_w, w_h;
    logic [msm_pkg::IDXW-1:0]  n_dq;
    logic [msm_pkg::SIZEW-1:0] n_drem;
    logic [msm_pkg::SIZEW:0]   w_rt;
    logic signed [1:0]         w_dx, w_dy;
    logic signed [10:0]        w_nx, w_ws;
    logic signed [13:0]        w_ny, w_hs;
    logic                      w_inx, w_iny, w_nok;
    logic [msm_pkg::NW-1:0]    w_n;
    logic [msm_pkg::NW-1:0]    w_idx17, w_cidx17;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_accept, w_store, w_take, w_fire;
    logic                      w_mask_bit, w_busy;
    msm_pkg::t_lane_ctl        w_ctl;
    logic [msm_pkg::DW-1:0]    w_wdata  [msm_pkg::NCOMP];
    logic [msm_pkg::DW-1:0]    w_smooth [msm_pkg::NCOMP];
    logic [msm_pkg::DW-1:0]    w_centre [msm_pkg::NCOMP];
    logic [msm_pkg::DW-1:0]    w_res    [msm_pkg::NCOMP];

    // grid sizes: zero reads as 1, above 256 saturates
    assign w_w = (r_width == '0) ? 9'd1 : ((r_width > 9'd256) ? 9'd256 : r_width);
    assign w_h = (r_height == '0) ? 9'd1 : ((r_height > 9'd256) ? 9'd256 : r_height);

    assign o_in_stall = (r_state != ST_IDLE) || w_busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_idx17    = msm_pkg::NW'(i_in_data.patch_index);
    assign w_cidx17   = msm_pkg::NW'(r_idx);
    assign w_store    = w_accept && (i_in_data.opcode == msm_pkg::OP_STORE)
                     && (w_idx17 < msm_pkg::NW'(MAX_PATCHES));
    assign w_fire     = (r_state == ST_FIN) && (!r_ovalid || !i_out_stall);

    // row / column divider, four bits a cycle
    always_comb begin
        n_dq   = r_dq;
        n_drem = r_drem;
        for (int i = 0; i < msm_pkg::DIGITS; i++) begin
            w_rt = {n_drem, n_dq[msm_pkg::IDXW-1]};
            n_dq = {n_dq[msm_pkg::IDXW-2:0], 1'b0};
            if (w_rt >= {1'b0, w_w}) begin
                n_drem  = msm_pkg::SIZEW'(w_rt - {1'b0, w_w});
                n_dq[0] = 1'b1;
            end else begin
                n_drem = w_rt[msm_pkg::SIZEW-1:0];
            end
        end
    end

    // neighbour address for the current step
    always_comb begin
        w_dx = msm_pkg::nb_dx(r_step);
        w_dy = msm_pkg::nb_dy(r_step);
        w_ws = $signed({2'b0, w_w});
        w_hs = $signed({5'b0, w_h});
        w_nx = $signed({2'b0, r_drem}) + 11'(w_dx);
        w_ny = $signed({2'b0, r_dq}) + 14'(w_dy);
        if (r_wrap_h) begin
            if (w_nx < 0) begin
                w_nx = w_nx + w_ws;
            end else if (w_nx >= w_ws) begin
                w_nx = w_nx - w_ws;
            end
        end
        if (r_wrap_v) begin
            if (w_ny < 0) begin
                w_ny = w_ny + w_hs;
            end else if (w_ny >= w_hs) begin
                w_ny = w_ny - w_hs;
            end
        end
        w_inx = (w_nx >= 0) && (w_nx < w_ws);
        w_iny = (w_ny >= 0) && (w_ny < w_hs);
        w_n   = msm_pkg::NW'(w_ny[7:0]) * msm_pkg::NW'(w_w) + msm_pkg::NW'(w_nx[7:0]);
        w_nok = w_inx && w_iny && (w_n < msm_pkg::NW'(MAX_PATCHES));
        if (r_state == ST_RD && r_step != '0) begin
            w_rd_addr = w_n[AW-1:0];
        end else begin
            w_rd_addr = w_cidx17[AW-1:0];
        end
    end

    assign w_take = r_pact && (r_pfirst || (r_pv && w_mask_bit));

    always_comb begin
        w_ctl.acc_en    = w_take;
        w_ctl.first     = r_pfirst;
        w_ctl.shift     = r_pshift;
        w_ctl.div_start = (r_state == ST_QST);
        w_ctl.div_step  = (r_state == ST_QDIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd64;
            r_height <= 9'd64;
            r_wrap_h <= 1'b0;
            r_wrap_v <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                msm_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata;
                msm_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                msm_pkg::CFG_WRAP_H: r_wrap_h <= i_cfg_wdata[0];
                msm_pkg::CFG_WRAP_V: r_wrap_v <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pact   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pact <= (r_state == ST_RD);
            if (w_fire) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_in_data.opcode == msm_pkg::OP_QUERY) begin
                        r_state <= ST_RC;
                    end
                end
                ST_RC: begin
                    if (r_dstep == 2'(RC_STEPS - 1)) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (r_step == 4'd8) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: r_state <= ST_QST;
                ST_QST:   r_state <= ST_QDIV;
                ST_QDIV: begin
                    if (r_qstep == 3'(Q_STEPS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_idx    <= i_in_data.patch_index;
            r_idx_ok <= w_idx17 < msm_pkg::NW'(MAX_PATCHES);
            r_dq     <= i_in_data.patch_index;
            r_drem   <= '0;
            r_dstep  <= '0;
            r_step   <= '0;
            r_wsum   <= msm_pkg::WTW'(16);
        end
        if (r_state == ST_RC) begin
            r_dq    <= n_dq;
            r_drem  <= n_drem;
            r_dstep <= r_dstep + 1'b1;
        end
        if (r_state == ST_RD) begin
            r_pfirst <= (r_step == '0);
            r_pv     <= w_nok;
            r_pshift <= msm_pkg::nb_shift(r_step);
            r_step   <= r_step + 1'b1;
        end
        if (r_pact && r_pfirst) begin
            r_cmask <= w_mask_bit;
        end
        if (w_take && !r_pfirst) begin
            r_wsum <= r_wsum + ((r_pshift == msm_pkg::SH_EDGE) ? 6'd4 : 6'd1);
        end
        if (r_state == ST_QST) begin
            r_qstep <= '0;
        end else if (r_state == ST_QDIV) begin
            r_qstep <= r_qstep + 1'b1;
        end
        if (w_fire) begin
            r_odata.result_index   <= r_idx;
            r_odata.smooth_unrad_x <= w_res[0];
            r_odata.smooth_unrad_y <= w_res[1];
            r_odata.smooth_unrad_z <= w_res[2];
            r_odata.smooth_total_x <= w_res[3];
            r_odata.smooth_total_y <= w_res[4];
            r_odata.smooth_total_z <= w_res[5];
            r_odata.smooth_dir_x   <= w_res[6];
            r_odata.smooth_dir_y   <= w_res[7];
            r_odata.smooth_dir_z   <= w_res[8];
        end
    end

    assign w_wdata[0] = i_in_data.unradiated_x;
    assign w_wdata[1] = i_in_data.unradiated_y;
    assign w_wdata[2] = i_in_data.unradiated_z;
    assign w_wdata[3] = i_in_data.total_x;
    assign w_wdata[4] = i_in_data.total_y;
    assign w_wdata[5] = i_in_data.total_z;
    assign w_wdata[6] = i_in_data.from_dir_x;
    assign w_wdata[7] = i_in_data.from_dir_y;
    assign w_wdata[8] = i_in_data.from_dir_z;

    msm_mask #(
        .MAX_PATCHES(MAX_PATCHES)
    ) u_mask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_store),
        .i_wr_addr (w_idx17[AW-1:0]),
        .i_wr_bit  (i_in_data.inside_flag),
        .i_rd_addr (w_rd_addr),
        .o_rd_bit  (w_mask_bit),
        .o_busy    (w_busy)
    );

    for (genvar g = 0; g < msm_pkg::NCOMP; g++) begin : g_lane
        msm_lane #(
            .MAX_PATCHES(MAX_PATCHES)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (w_store),
            .i_wr_addr (w_idx17[AW-1:0]),
            .i_wr_data (w_wdata[g]),
            .i_rd_addr (w_rd_addr),
            .i_ctl     (w_ctl),
            .i_weight  (r_wsum),
            .o_smooth  (w_smooth[g]),
            .o_centre  (w_centre[g])
        );

        // merge: off-range index gives zero, outside patch or row passes through
        assign w_res[g] = !r_idx_ok ? '0
                        : (!r_cmask || r_dq >= msm_pkg::IDXW'(w_h)) ? w_centre[g]
                        : w_smooth[g];
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef NO_ASSERTIONS
    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_in_stall)
        else $error("input taken during mask clearing");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QST || r_state == ST_QDIV || r_state == ST_FIN)
        |-> (r_wsum >= 6'd16 && r_wsum <= 6'd36))
        else $error("total weight out of range");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("result word without finished query");

    a_acc_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pact |-> (r_state == ST_RD || r_state == ST_DRAIN))
        else $error("accumulate outside read phase");
`endif

endmodule
